@@ rtl/uttc_pkg.sv @@
// shared types, constants and calendar helpers for the timestamp-to-calendar block
package uttc_pkg;

   // divider operand widths
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 17;

   // field widths
   localparam int DAYS_W  = 16;
   localparam int YEAR_W  = 12;
   localparam int DOY_W   = 9;

   // reciprocal multiplier widths: shifted dividend, magic constant, product; remainder product
   localparam int RECIP_W    = 25;
   localparam int MAGIC_W    = 26;
   localparam int PROD_W     = RECIP_W + MAGIC_W;
   localparam int REM_PROD_W = DAYS_W + DIVISOR_W;

   // quotient by reciprocal: ((dividend >> pre) * magic) >> post
   // seconds per day is 128 * 675, 60 is 4 * 15
   localparam int               DAY_PRE    = 7;
   localparam logic [MAGIC_W-1:0] DAY_MAGIC  = 26'd50903317;
   localparam int               DAY_POST   = 35;
   localparam int               SIXTY_PRE  = 2;
   localparam logic [MAGIC_W-1:0] SOD_MAGIC  = 26'd34953;
   localparam int               SOD_POST   = 19;
   localparam logic [MAGIC_W-1:0] MINS_MAGIC = 26'd547;
   localparam int               MINS_POST  = 13;
   localparam logic [MAGIC_W-1:0] WEEK_MAGIC = 26'd74899;
   localparam int               WEEK_POST  = 19;

   // time and calendar constants
   localparam logic [DIVISOR_W-1:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [DIVISOR_W-1:0] SECS_PER_MIN   = 17'd60;
   localparam logic [DIVISOR_W-1:0] MINS_PER_HOUR  = 17'd60;
   localparam logic [DIVISOR_W-1:0] DAYS_PER_WEEK  = 17'd7;
   localparam logic [DIVISOR_W-1:0] EPOCH_WEEKDAY  = 17'd4;
   localparam logic [YEAR_W-1:0]    EPOCH_YEAR     = 12'd1970;
   localparam logic [YEAR_W-1:0]    NON_LEAP_CENT  = 12'd2100;
   localparam logic [DOY_W-1:0]     DAYS_LEAP      = 9'd366;
   localparam logic [DOY_W-1:0]     DAYS_COMMON    = 9'd365;
   localparam logic [DAYS_W-1:0]    LEAP_DAY_INDEX = 16'd59;
   localparam logic [3:0]           MONTH_LAST     = 4'd11;
   localparam logic [3:0]           FEBRUARY       = 4'd2;
   localparam logic [4:0]           LEAP_DAY_MDAY  = 5'd29;

   // which division the shared divider is running
   typedef enum logic [1:0] {
      SEL_DAY  = 2'd0,  // timestamp / seconds per day
      SEL_SEC  = 2'd1,  // seconds of day / 60
      SEL_MIN  = 2'd2,  // minutes of day / 60
      SEL_WEEK = 2'd3   // (days + 4) mod 7
   } div_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        div_init;
      div_sel_type init_sel;
      logic        div_step;
      logic        div_capture;
      div_sel_type div_sel;
      logic        year_step;
      logic        month_init;
      logic        month_step;
      logic        result_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic year_done;
      logic month_done;
   } status_type;

   // gregorian leap rule over 1970..2106: 2000 is leap, 2100 is the one
   // century in range that is not
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      return (y[1:0] == 2'b00) && (y != NON_LEAP_CENT);
   endfunction

   // day index of the first day of each month, non-leap year
   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m);
      logic [DOY_W-1:0] r;
      case (m)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/uttc_ctrl.sv @@
// sequencing controller for the timestamp-to-calendar block
module uttc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                done,
   output uttc_pkg::cmd_type   cmd,
   input  uttc_pkg::status_type status
);
   import uttc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_YEAR,
      ST_MONTH_FIX,
      ST_MONTH_SEARCH,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   div_sel_type              sel_ff;
   logic                     busy_ff;
   logic                     done_ff;
   div_sel_type              next_sel;

   // order of the four divisions
   always_comb begin
      case (sel_ff)
         SEL_DAY: next_sel = SEL_SEC;
         SEL_SEC: next_sel = SEL_MIN;
         SEL_MIN: next_sel = SEL_WEEK;
         default: next_sel = SEL_DAY;
      endcase
   end

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.div_sel  = sel_ff;
      cmd.init_sel = SEL_DAY;
      case (state_ff)
         ST_IDLE: begin
            cmd.div_init = start;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
         end
         ST_DIV_DONE: begin
            cmd.div_capture = 1'b1;
            cmd.div_init    = (sel_ff != SEL_WEEK);
            cmd.init_sel    = next_sel;
         end
         ST_YEAR: begin
            cmd.year_step = !status.year_done;
         end
         ST_MONTH_FIX: begin
            cmd.month_init = 1'b1;
         end
         ST_MONTH_SEARCH: begin
            cmd.month_step = !status.month_done;
         end
         ST_FINISH: begin
            cmd.result_load = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_DAY;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DIV_STEP;
                  sel_ff   <= SEL_DAY;
                  busy_ff  <= 1'b1;
               end
            end
            ST_DIV_STEP: begin
               state_ff <= ST_DIV_DONE;
            end
            ST_DIV_DONE: begin
               sel_ff <= next_sel;
               if (sel_ff == SEL_WEEK) begin
                  state_ff <= ST_YEAR;
               end else begin
                  state_ff <= ST_DIV_STEP;
               end
            end
            ST_YEAR: begin
               if (status.year_done) begin
                  state_ff <= ST_MONTH_FIX;
               end
            end
            ST_MONTH_FIX: begin
               state_ff <= ST_MONTH_SEARCH;
            end
            ST_MONTH_SEARCH: begin
               if (status.month_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
               done_ff  <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

@@ rtl/uttc_datapath.sv @@
// shared reciprocal divider, year and month search, result registers
module uttc_datapath (
   input  logic                  clock,
   input  uttc_pkg::cmd_type     cmd,
   output uttc_pkg::status_type  status,
   input  logic [31:0]           req_unix_seconds,
   output logic [11:0]           rsp_year,
   output logic [3:0]            rsp_month,
   output logic [4:0]            rsp_day_of_month,
   output logic [2:0]            rsp_weekday,
   output logic [4:0]            rsp_hour,
   output logic [5:0]            rsp_minute,
   output logic [5:0]            rsp_second
);
   import uttc_pkg::*;

   // divider
   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [DAYS_W-1:0]     quo_ff;
   logic [DIVIDEND_W-1:0] dividend_in;
   logic [DIVISOR_W-1:0]  divisor;
   logic [RECIP_W-1:0]    recip_in;
   logic [MAGIC_W-1:0]    magic;
   logic [PROD_W-1:0]     recip_prod;
   logic [DAYS_W-1:0]     quo_next;
   logic [REM_PROD_W-1:0] rem_prod;
   logic [DIVIDEND_W-1:0] rem_full;

   // intermediate fields
   logic [DAYS_W-1:0]     days_ff;
   logic [5:0]            sec_ff;
   logic [5:0]            min_ff;
   logic [4:0]            hour_ff;
   logic [2:0]            wday_ff;
   logic [YEAR_W-1:0]     year_ff;
   logic [3:0]            mon_ff;
   logic                  feb29_ff;

   // result registers
   logic [11:0]           res_year_ff;
   logic [3:0]            res_month_ff;
   logic [4:0]            res_mday_ff;
   logic [2:0]            res_wday_ff;
   logic [4:0]            res_hour_ff;
   logic [5:0]            res_min_ff;
   logic [5:0]            res_sec_ff;

   logic                  leap;
   logic [DOY_W-1:0]      year_len;
   logic [DOY_W-1:0]      mstart;
   logic [DOY_W-1:0]      mday_full;

   // dividend for the next division: the request timestamp, or a result of an earlier division
   always_comb begin
      case (cmd.init_sel)
         SEL_DAY:  dividend_in = req_unix_seconds;
         SEL_SEC:  dividend_in = rem_full;
         SEL_MIN:  dividend_in = DIVIDEND_W'(quo_ff);
         SEL_WEEK: dividend_in = DIVIDEND_W'({1'b0, days_ff} + EPOCH_WEEKDAY);
         default:  dividend_in = '0;
      endcase
   end

   // divisor of the division in progress
   always_comb begin
      case (cmd.div_sel)
         SEL_DAY:  divisor = SECS_PER_DAY;
         SEL_SEC:  divisor = SECS_PER_MIN;
         SEL_MIN:  divisor = MINS_PER_HOUR;
         SEL_WEEK: divisor = DAYS_PER_WEEK;
         default:  divisor = SECS_PER_DAY;
      endcase
   end

   // reciprocal operands, exact over each dividend's range
   always_comb begin
      case (cmd.div_sel)
         SEL_DAY: begin
            recip_in = RECIP_W'(dvd_ff >> DAY_PRE);
            magic    = DAY_MAGIC;
         end
         SEL_SEC: begin
            recip_in = RECIP_W'(dvd_ff >> SIXTY_PRE);
            magic    = SOD_MAGIC;
         end
         SEL_MIN: begin
            recip_in = RECIP_W'(dvd_ff >> SIXTY_PRE);
            magic    = MINS_MAGIC;
         end
         SEL_WEEK: begin
            recip_in = RECIP_W'(dvd_ff);
            magic    = WEEK_MAGIC;
         end
         default: begin
            recip_in = '0;
            magic    = '0;
         end
      endcase
   end

   assign recip_prod = PROD_W'(recip_in) * PROD_W'(magic);

   // quotient from the high part of the product
   always_comb begin
      case (cmd.div_sel)
         SEL_DAY:  quo_next = DAYS_W'(recip_prod >> DAY_POST);
         SEL_SEC:  quo_next = DAYS_W'(recip_prod >> SOD_POST);
         SEL_MIN:  quo_next = DAYS_W'(recip_prod >> MINS_POST);
         SEL_WEEK: quo_next = DAYS_W'(recip_prod >> WEEK_POST);
         default:  quo_next = '0;
      endcase
   end

   // remainder from the registered quotient
   assign rem_prod = REM_PROD_W'(quo_ff) * REM_PROD_W'(divisor);
   assign rem_full = dvd_ff - rem_prod[DIVIDEND_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dvd_ff <= dividend_in;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_next;
      end
   end

   // year and month helpers
   assign leap     = is_leap(year_ff);
   assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;
   assign mstart   = month_start(mon_ff);
   assign mday_full = days_ff[DOY_W-1:0] - mstart + 9'd1;

   assign status.year_done  = (days_ff < DAYS_W'(year_len));
   assign status.month_done = feb29_ff || (mon_ff == '0) ||
                              (DAYS_W'(mstart) <= days_ff);

   // capture division results, then walk years and months
   always_ff @(posedge clock) begin
      if (cmd.div_capture) begin
         case (cmd.div_sel)
            SEL_DAY: begin
               days_ff <= quo_ff;
            end
            SEL_SEC: begin
               sec_ff  <= rem_full[5:0];
            end
            SEL_MIN: begin
               min_ff  <= rem_full[5:0];
               hour_ff <= quo_ff[4:0];
            end
            SEL_WEEK: begin
               wday_ff <= rem_full[2:0];
               year_ff <= EPOCH_YEAR;
            end
            default: begin
               wday_ff <= rem_full[2:0];
            end
         endcase
      end else if (cmd.year_step) begin
         days_ff <= days_ff - DAYS_W'(year_len);
         year_ff <= year_ff + YEAR_W'(1);
      end else if (cmd.month_init) begin
         mon_ff   <= MONTH_LAST;
         feb29_ff <= leap && (days_ff == LEAP_DAY_INDEX);
         // days after the leap day line up with the non-leap table
         if (leap && (days_ff > LEAP_DAY_INDEX)) begin
            days_ff <= days_ff - DAYS_W'(1);
         end
      end else if (cmd.month_step) begin
         mon_ff <= mon_ff - 4'd1;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         res_year_ff <= year_ff;
         res_wday_ff <= wday_ff;
         res_hour_ff <= hour_ff;
         res_min_ff  <= min_ff;
         res_sec_ff  <= sec_ff;
         if (feb29_ff) begin
            res_month_ff <= FEBRUARY;
            res_mday_ff  <= LEAP_DAY_MDAY;
         end else begin
            res_month_ff <= mon_ff + 4'd1;
            res_mday_ff  <= mday_full[4:0];
         end
      end
   end

   assign rsp_year         = res_year_ff;
   assign rsp_month        = res_month_ff;
   assign rsp_day_of_month = res_mday_ff;
   assign rsp_weekday      = res_wday_ff;
   assign rsp_hour         = res_hour_ff;
   assign rsp_minute       = res_min_ff;
   assign rsp_second       = res_sec_ff;

endmodule

@@ rtl/unix_time_to_calendar_core.sv @@
// top level of the unix timestamp to calendar date converter
//
// Usage: drive req_unix_seconds and raise start while busy is low; the
// request is taken at that clock edge and busy rises on the next cycle.
// One request gives one result: year, month, day of month, weekday
// (0 = Sunday), hour, minute and second, shown on the rsp_ ports for
// exactly one cycle with rsp_valid high. The result ports hold their value
// afterwards until the next result is loaded.
// rsp_valid is high in the cycle after busy ends.
// Four divisions by constants (seconds per day, 60, 60, 7) run in turn on a
// shared reciprocal multiplier, each as a quotient step and a remainder
// step; the year loop subtracts one year per cycle and stops when fewer
// days than a year remain; a set-up state prepares the month search, which
// walks the month table one entry per cycle, and a final state loads the
// result.
// One request at a time: busy falls in the cycle rsp_valid is high, and a
// new request can be taken at the end of that cycle.
// Reset (synchronous, active high) returns the controller to idle and
// clears busy and rsp_valid. The receiver cannot stall: each result is
// taken in the cycle it is shown.
module unix_time_to_calendar_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_unix_seconds,
   output logic        rsp_valid,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [2:0]  rsp_weekday,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);
   import uttc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller
   uttc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .done   (rsp_valid),
      .cmd    (cmd),
      .status (status)
   );

   // datapath
   uttc_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_unix_seconds (req_unix_seconds),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_weekday      (rsp_weekday),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // a result strobe never comes while still busy, and lasts one cycle
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$past(rsp_valid)))
      else $error("result strobe while busy or longer than one cycle");

   // month of a delivered result is a calendar month
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_month >= 4'd1) && (rsp_month <= 4'd12)))
      else $error("month out of range");

   // the year loop only steps while the remaining days are at least a year
   a_year_step: assert property (@(posedge clock) disable iff (reset)
      cmd.year_step |-> !status.year_done)
      else $error("year stepped past the end");

endmodule
